@@ rtl/rmv_pkg.sv @@
package rmv_pkg;

  // Sample format and the extra fraction bits carried by the running mean.
  localparam int SAMPLE_W   = 32;
  localparam int FRAC_W     = 16;
  localparam int MEAN_XFRAC = 16;
  localparam int MEAN_W     = SAMPLE_W + MEAN_XFRAC;
  // Magnitude of a difference of two means, one bit wider than the mean.
  localparam int MAG_W      = MEAN_W + 1;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int PROD_SHIFT = 2 * MEAN_XFRAC;
  localparam int CNT_W      = 32;
  localparam int SUM_W      = 64;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int SQREM_W    = ROOT_W + 2;
  localparam int ITER_W     = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEAN_W-1:0]   mean_t;
  typedef logic [MAG_W-1:0]           mag_t;
  typedef logic [CNT_W-1:0]           count_t;
  typedef logic [SUM_W-1:0]           sum_t;

endpackage

@@ rtl/running_mean_variance_min_max.sv @@
// Running statistics of a stream of signed Q16.16 samples (Welford's method).
// Input channel: in_valid / in_ready with one sample per word. Result channel:
// out_valid / out_ready with one word per sample: the saturating count, the
// running mean, the minimum, the maximum and the population standard deviation.
// The block works on one sample at a time. After a word is accepted, in_ready
// stays low until the result word appears, and in_ready rises again in that
// same cycle. The work is done by serial arithmetic: a shared restoring
// divider retiring one quotient bit per cycle is used twice (49 steps for the
// mean update, 64 steps for the sum divided by the count), a shift-add
// multiplier takes 49 steps and the square root takes 32 steps of two bits
// each.
// The result register parts the two sides: a new sample is taken while the
// previous result still waits. If the receiver stalls for longer than one
// sample's work, the block holds the finished result internally and stays busy
// until the output register is free.
// A synchronous active-low reset clears the count, mean and sum, sets the
// minimum to the most positive and the maximum to the most negative value, and
// leaves the block idle with no result pending.
module running_mean_variance_min_max (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rmv_pkg::sample_t       in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rmv_pkg::count_t        out_sample_count,
  output rmv_pkg::sample_t       out_mean_value,
  output rmv_pkg::sample_t       out_min_value,
  output rmv_pkg::sample_t       out_max_value,
  output logic [rmv_pkg::SAMPLE_W-1:0] out_std_dev
);
  import rmv_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV1 = 4'd1;  // delta magnitude divided by the count
  localparam logic [3:0] S_MEAN = 4'd2;  // apply the mean step
  localparam logic [3:0] S_MSET = 4'd3;  // second deviation, load the multiplier
  localparam logic [3:0] S_MUL  = 4'd4;  // shift-add product of the deviations
  localparam logic [3:0] S_ACC  = 4'd5;  // saturating add into the sum
  localparam logic [3:0] S_DIV2 = 4'd6;  // sum divided by the count
  localparam logic [3:0] S_SQRT = 4'd7;  // digit-by-digit square root
  localparam logic [3:0] S_OUT  = 4'd8;  // hand the word to the output register

  localparam logic [ITER_W-1:0] DIV1_LAST = ITER_W'(MAG_W - 1);
  localparam logic [ITER_W-1:0] MUL_LAST  = ITER_W'(MAG_W - 1);
  localparam logic [ITER_W-1:0] DIV2_LAST = ITER_W'(SUM_W - 1);
  localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(ROOT_W - 1);

  logic [3:0]        state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  count_t            count_r, count_nxt;
  mean_t             mean_r, mean_nxt;
  sum_t              sq_r, sq_nxt;
  sample_t           min_r, min_nxt;
  sample_t           max_r, max_nxt;
  mean_t             sx_r, sx_nxt;
  logic              neg_r, neg_nxt;
  mag_t              mag_r, mag_nxt;
  // Shared shift register: dividend in, quotient out; then the radicand.
  sum_t              dq_r, dq_nxt;
  logic [SQREM_W-1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [MAG_W-1:0]  acc_r, acc_nxt;
  logic [MAG_W-1:0]  mpl_r, mpl_nxt;

  logic              out_valid_r, out_valid_nxt;
  count_t            ocount_r, ocount_nxt;
  sample_t           omean_r, omean_nxt;
  sample_t           omin_r, omin_nxt;
  sample_t           omax_r, omax_nxt;
  logic [SAMPLE_W-1:0] ostd_r, ostd_nxt;

  // Difference of a scaled sample and the mean, as sign and magnitude.
  mean_t             sx_in;
  logic [MAG_W-1:0]  diff_a;
  logic [MAG_W-1:0]  diff_b;
  logic              neg_b;
  mag_t              mag_a;
  mag_t              mag_b;

  // One restoring division step.
  logic [CNT_W:0]    div_sh;
  logic              div_ge;
  logic [CNT_W:0]    div_sub;

  // One multiplier step.
  logic [MAG_W:0]    mul_sum;

  // Saturating sum update.
  logic [PROD_W-1:0] prod;
  sum_t              inc;
  logic [SUM_W:0]    sq_add;
  sum_t              sq_new;

  // One square root step.
  logic [SQREM_W+1:0] sq_sh;
  logic [SQREM_W+1:0] sq_try;
  logic              sq_ge;
  logic [SQREM_W+1:0] sq_sub;

  assign in_ready = (state_r == S_IDLE);

  assign sx_in  = {in_sample, {MEAN_XFRAC{1'b0}}};
  assign diff_a = {sx_in[MEAN_W-1], sx_in} - {mean_r[MEAN_W-1], mean_r};
  assign mag_a  = diff_a[MAG_W-1] ? (~diff_a + MAG_W'(1)) : diff_a;
  assign diff_b = {sx_r[MEAN_W-1], sx_r} - {mean_r[MEAN_W-1], mean_r};
  assign neg_b  = diff_b[MAG_W-1];
  assign mag_b  = neg_b ? (~diff_b + MAG_W'(1)) : diff_b;

  assign div_sh  = {rem_r[CNT_W-1:0], dq_r[SUM_W-1]};
  assign div_ge  = (div_sh >= {1'b0, count_r});
  assign div_sub = div_sh - {1'b0, count_r};

  assign mul_sum = {1'b0, acc_r} + (mpl_r[0] ? {1'b0, mag_r} : {(MAG_W + 1){1'b0}});

  // Increment is the product shifted down, saturated to the sum's width.
  assign prod   = {acc_r, mpl_r};
  assign inc    = (prod[PROD_W-1:PROD_SHIFT+SUM_W] != '0) ? {SUM_W{1'b1}}
                                                          : prod[PROD_SHIFT +: SUM_W];
  assign sq_add = {1'b0, sq_r} + {1'b0, inc};
  assign sq_new = sq_add[SUM_W] ? {SUM_W{1'b1}} : sq_add[SUM_W-1:0];

  assign sq_sh  = {rem_r, dq_r[SUM_W-1:SUM_W-2]};
  assign sq_try = {{SQREM_W-ROOT_W{1'b0}}, root_r, 2'b01};
  assign sq_ge  = (sq_sh >= sq_try);
  assign sq_sub = sq_sh - sq_try;

  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    count_nxt     = count_r;
    mean_nxt      = mean_r;
    sq_nxt        = sq_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sx_nxt        = sx_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    acc_nxt       = acc_r;
    mpl_nxt       = mpl_r;
    out_valid_nxt = out_valid_r;
    ocount_nxt    = ocount_r;
    omean_nxt     = omean_r;
    omin_nxt      = omin_r;
    omax_nxt      = omax_r;
    ostd_nxt      = ostd_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sx_nxt    = sx_in;
          count_nxt = (count_r == {CNT_W{1'b1}}) ? count_r : count_r + CNT_W'(1);
          if (in_sample < min_r) begin
            min_nxt = in_sample;
          end
          if (in_sample > max_r) begin
            max_nxt = in_sample;
          end
          neg_nxt   = diff_a[MAG_W-1];
          mag_nxt   = mag_a;
          // Dividend left-aligned so its top bit enters the divider first.
          dq_nxt    = {mag_a, {(SUM_W - MAG_W){1'b0}}};
          rem_nxt   = '0;
          iter_nxt  = '0;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1, S_DIV2: begin
        rem_nxt  = {{(SQREM_W - CNT_W){1'b0}},
                    (div_ge ? div_sub[CNT_W-1:0] : div_sh[CNT_W-1:0])};
        dq_nxt   = {dq_r[SUM_W-2:0], div_ge};
        iter_nxt = iter_r + ITER_W'(1);
        if (state_r == S_DIV1 && iter_r == DIV1_LAST) begin
          state_nxt = S_MEAN;
        end else if (state_r == S_DIV2 && iter_r == DIV2_LAST) begin
          // The square root starts with an empty remainder and root.
          rem_nxt   = '0;
          root_nxt  = '0;
          iter_nxt  = '0;
          state_nxt = S_SQRT;
        end
      end
      S_MEAN: begin
        // The quotient never exceeds the delta, so the mean stays in range.
        mean_nxt  = neg_r ? mean_r - dq_r[MEAN_W-1:0] : mean_r + dq_r[MEAN_W-1:0];
        state_nxt = S_MSET;
      end
      S_MSET: begin
        // Deviations of opposite sign contribute nothing to the sum.
        acc_nxt   = '0;
        mpl_nxt   = (neg_b == neg_r) ? mag_b : '0;
        iter_nxt  = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        acc_nxt  = mul_sum[MAG_W:1];
        mpl_nxt  = {mul_sum[0], mpl_r[MAG_W-1:1]};
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == MUL_LAST) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        sq_nxt    = sq_new;
        dq_nxt    = sq_new;
        rem_nxt   = '0;
        iter_nxt  = '0;
        state_nxt = S_DIV2;
      end
      S_SQRT: begin
        rem_nxt  = sq_ge ? sq_sub[SQREM_W-1:0] : sq_sh[SQREM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], sq_ge};
        dq_nxt   = {dq_r[SUM_W-3:0], 2'b00};
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == SQRT_LAST) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          ocount_nxt    = count_r;
          omean_nxt     = mean_r[MEAN_W-1:MEAN_XFRAC];
          omin_nxt      = min_r;
          omax_nxt      = max_r;
          ostd_nxt      = SAMPLE_W'(root_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      mean_r      <= '0;
      sq_r        <= '0;
      min_r       <= {1'b0, {(SAMPLE_W - 1){1'b1}}};
      max_r       <= {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      mean_r      <= mean_nxt;
      sq_r        <= sq_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iter_r   <= iter_nxt;
    sx_r     <= sx_nxt;
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    dq_r     <= dq_nxt;
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    acc_r    <= acc_nxt;
    mpl_r    <= mpl_nxt;
    ocount_r <= ocount_nxt;
    omean_r  <= omean_nxt;
    omin_r   <= omin_nxt;
    omax_r   <= omax_nxt;
    ostd_r   <= ostd_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sample_count = ocount_r;
  assign out_mean_value   = omean_r;
  assign out_min_value    = omin_r;
  assign out_max_value    = omax_r;
  assign out_std_dev      = ostd_r;

endmodule
